>>> src/plr_pkg.sv
// shared widths, register indexes, payload structs and a saturation helper for the point light shader
package plr_pkg;

    // lanes: one per axis or color channel
    localparam int LANES      = 3;

    // field widths
    localparam int W_POS      = 32;
    localparam int W_NRM      = 16;
    localparam int W_COLOR    = 17;
    localparam int W_OFF      = 16;
    localparam int W_PROD_OFF = W_OFF + W_NRM + 1;
    localparam int W_ORG_SUM  = W_POS + 2;
    localparam int W_CFG_IDX  = 3;
    localparam int W_CFG_DATA = 32;

    // distance path widths
    localparam int W_AD       = W_POS + 1;
    localparam int W_SQ       = 2 * W_AD;
    localparam int W_SUM      = W_SQ;
    localparam int W_ROOT     = 34;
    localparam int W_REM_SQ   = W_ROOT + 2;
    localparam int W_DIST     = 32;
    localparam int W_LO       = 64;

    // direction divider widths
    localparam int DIR_FRAC   = 14;
    localparam int W_DIRQ     = DIR_FRAC + 1;
    localparam int W_DIRN     = W_AD + DIR_FRAC;
    localparam int W_DIR      = 16;

    // contribution path widths
    localparam int W_DOT      = 32;
    localparam int W_DOTP     = W_DOT - 1;
    localparam int W_CMUL     = W_COLOR + W_DOTP;
    localparam int CSHIFT     = 4;
    localparam int W_CNUM     = W_CMUL + CSHIFT;
    localparam int W_CQ       = 32;

    // rounding constant for the origin offset
    localparam logic signed [W_PROD_OFF-1:0] OFF_HALF = W_PROD_OFF'(1 << (DIR_FRAC - 1));

    // configuration register indexes
    localparam logic [W_CFG_IDX-1:0] REG_LIGHT_X     = 3'd0;
    localparam logic [W_CFG_IDX-1:0] REG_LIGHT_Y     = 3'd1;
    localparam logic [W_CFG_IDX-1:0] REG_LIGHT_Z     = 3'd2;
    localparam logic [W_CFG_IDX-1:0] REG_LIGHT_RED   = 3'd3;
    localparam logic [W_CFG_IDX-1:0] REG_LIGHT_GREEN = 3'd4;
    localparam logic [W_CFG_IDX-1:0] REG_LIGHT_BLUE  = 3'd5;
    localparam logic [W_CFG_IDX-1:0] REG_SURF_OFFSET = 3'd6;

    // reset values
    localparam logic [W_COLOR-1:0] COLOR_RESET  = 17'd65536;
    localparam logic [W_OFF-1:0]   OFFSET_RESET = 16'd7;

    // side data riding along the square root
    typedef struct packed {
        logic [LANES-1:0][W_POS-1:0] origin;
        logic [LANES-1:0][W_AD-1:0]  ad;
        logic [LANES-1:0]            sd;
        logic [LANES-1:0][W_NRM-1:0] nrm;
        logic [W_SUM-1:0]            s;
        logic                        degen;
    } t_tag_a;

    // side data riding along the direction divider
    typedef struct packed {
        logic [LANES-1:0][W_POS-1:0] origin;
        logic [LANES-1:0]            sd;
        logic [LANES-1:0][W_NRM-1:0] nrm;
        logic [W_DIST-1:0]           ray_len;
        logic [W_LO-1:0]             lo;
        logic                        hi_nz;
        logic                        degen;
    } t_tag_b;

    // side data for the shading tail and contribution divider
    typedef struct packed {
        logic [LANES-1:0][W_POS-1:0] origin;
        logic [LANES-1:0][W_DIR-1:0] dir;
        logic [W_DIST-1:0]           ray_len;
        logic [W_LO-1:0]             lo;
        logic                        hi_nz;
        logic                        degen;
        logic                        kill;
        logic [LANES-1:0]            ovf;
    } t_post;

    // clamp a widened signed sum to 32 bits
    function automatic logic [W_POS-1:0] sat_s32(input logic signed [W_ORG_SUM-1:0] v);
        logic signed [W_ORG_SUM-1:0] hi_lim;
        logic signed [W_ORG_SUM-1:0] lo_lim;
        hi_lim = W_ORG_SUM'(64'sd2147483647);
        lo_lim = -W_ORG_SUM'(64'sd2147483648);
        if (v > hi_lim) begin
            return 32'h7FFF_FFFF;
        end else if (v < lo_lim) begin
            return 32'h8000_0000;
        end
        return v[W_POS-1:0];
    endfunction

endpackage

>>> src/plr_hit_if.sv
// hit point channel: valid, ready and the hit point and normal word
interface plr_hit_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [plr_pkg::W_POS-1:0]     hit_x;
    logic signed [plr_pkg::W_POS-1:0]     hit_y;
    logic signed [plr_pkg::W_POS-1:0]     hit_z;
    logic signed [plr_pkg::W_NRM-1:0]     normal_x;
    logic signed [plr_pkg::W_NRM-1:0]     normal_y;
    logic signed [plr_pkg::W_NRM-1:0]     normal_z;

    modport source (
        output valid, hit_x, hit_y, hit_z, normal_x, normal_y, normal_z,
        input  ready
    );
    modport sink (
        input  valid, hit_x, hit_y, hit_z, normal_x, normal_y, normal_z,
        output ready
    );
endinterface

>>> src/plr_shade_if.sv
// shading result channel: valid, ready and the shadow ray and contribution word
interface plr_shade_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [plr_pkg::W_POS-1:0]     origin_x;
    logic signed [plr_pkg::W_POS-1:0]     origin_y;
    logic signed [plr_pkg::W_POS-1:0]     origin_z;
    logic signed [plr_pkg::W_DIR-1:0]     dir_x;
    logic signed [plr_pkg::W_DIR-1:0]     dir_y;
    logic signed [plr_pkg::W_DIR-1:0]     dir_z;
    logic [plr_pkg::W_DIST-1:0]           light_distance;
    logic [plr_pkg::W_CQ-1:0]             contrib_red;
    logic [plr_pkg::W_CQ-1:0]             contrib_green;
    logic [plr_pkg::W_CQ-1:0]             contrib_blue;
    logic                                 degenerate;

    modport source (
        output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
               light_distance, contrib_red, contrib_green, contrib_blue, degenerate,
        input  ready
    );
    modport sink (
        input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
               light_distance, contrib_red, contrib_green, contrib_blue, degenerate,
        output ready
    );
endinterface

>>> src/point_light_shadow_ray_and_lambert_top.sv
// point light shading: shadow ray origin, direction, distance and Lambert contribution
//
// Usage:
//   i_hit carries one word per surface hit: hit point (Q16.16) and unit normal (Q2.14).
//   o_shade returns one word per hit: offset shadow ray origin, unit direction to the
//   light, distance to the light and the red/green/blue contribution, plus a flag when
//   the hit point sits on the light.
//   The light position, color and surface offset are written through i_cfg_we /
//   i_cfg_idx / i_cfg_data while no word is in flight; indexes above six are ignored.
// Pipeline:
//   the pipeline has 90 register stages: the 34-stage square root, the 15-stage
//   direction divider and the 32-stage contribution divider plus nine stages of
//   shaping logic (stages a to h and the output register).
//   One word is accepted per cycle for as long as the output is drained.
// Reset and stall:
//   reset empties the pipeline and loads the light at the origin, white color and a
//   surface offset of 7. When o_shade is held off, the whole pipeline freezes and
//   i_hit.ready drops until the output word is taken; nothing is lost or repeated.
module point_light_shadow_ray_and_lambert_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [plr_pkg::W_CFG_IDX-1:0]       i_cfg_idx,
    input  logic [plr_pkg::W_CFG_DATA-1:0]      i_cfg_data,
    plr_hit_if.sink                             i_hit,
    plr_shade_if.source                         o_shade
);
    localparam int L = plr_pkg::LANES;

    // configuration registers
    logic [L-1:0][plr_pkg::W_POS-1:0]   r_light_pos;
    logic [L-1:0][plr_pkg::W_COLOR-1:0] r_color;
    logic [plr_pkg::W_OFF-1:0]          r_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_pos <= '0;
            r_color     <= {L{plr_pkg::COLOR_RESET}};
            r_offset    <= plr_pkg::OFFSET_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                plr_pkg::REG_LIGHT_X:     r_light_pos[0] <= i_cfg_data;
                plr_pkg::REG_LIGHT_Y:     r_light_pos[1] <= i_cfg_data;
                plr_pkg::REG_LIGHT_Z:     r_light_pos[2] <= i_cfg_data;
                plr_pkg::REG_LIGHT_RED:   r_color[0] <= i_cfg_data[plr_pkg::W_COLOR-1:0];
                plr_pkg::REG_LIGHT_GREEN: r_color[1] <= i_cfg_data[plr_pkg::W_COLOR-1:0];
                plr_pkg::REG_LIGHT_BLUE:  r_color[2] <= i_cfg_data[plr_pkg::W_COLOR-1:0];
                plr_pkg::REG_SURF_OFFSET: r_offset <= i_cfg_data[plr_pkg::W_OFF-1:0];
                default: ;
            endcase
        end
    end

    // pipeline advance: move whenever the output register is empty or being taken
    logic w_en;
    logic r_vo;
    assign w_en        = !r_vo || o_shade.ready;
    assign i_hit.ready = w_en;

    // stage a: light minus hit, magnitudes, origin offset product
    logic [L-1:0][plr_pkg::W_POS-1:0] w_hit;
    logic [L-1:0][plr_pkg::W_NRM-1:0] w_nrm;
    assign w_hit = {i_hit.hit_z, i_hit.hit_y, i_hit.hit_x};
    assign w_nrm = {i_hit.normal_z, i_hit.normal_y, i_hit.normal_x};

    logic                                   r_va;
    logic [L-1:0][plr_pkg::W_POS-1:0]       r_a_hit;
    logic [L-1:0][plr_pkg::W_NRM-1:0]       r_a_nrm;
    logic [L-1:0][plr_pkg::W_AD-1:0]        r_a_ad;
    logic [L-1:0]                           r_a_sd;
    logic [L-1:0][plr_pkg::W_PROD_OFF-1:0]  r_a_p;
    logic [L-1:0][plr_pkg::W_AD-1:0]        n_a_ad;
    logic [L-1:0]                           n_a_sd;
    logic [L-1:0][plr_pkg::W_PROD_OFF-1:0]  n_a_p;

    always_comb begin
        logic [plr_pkg::W_AD-1:0]             d;
        logic signed [plr_pkg::W_PROD_OFF-1:0] p;
        for (int k = 0; k < L; k++) begin
            d = {r_light_pos[k][plr_pkg::W_POS-1], r_light_pos[k]}
              - {w_hit[k][plr_pkg::W_POS-1], w_hit[k]};
            n_a_sd[k] = d[plr_pkg::W_AD-1];
            n_a_ad[k] = d[plr_pkg::W_AD-1] ? (~d + plr_pkg::W_AD'(1)) : d;
            p = $signed({1'b0, r_offset}) * $signed(w_nrm[k]);
            n_a_p[k] = p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (w_en) begin
            r_va <= i_hit.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_hit <= w_hit;
            r_a_nrm <= w_nrm;
            r_a_ad  <= n_a_ad;
            r_a_sd  <= n_a_sd;
            r_a_p   <= n_a_p;
        end
    end

    // stage b: squares and saturated origin
    logic                              r_vb;
    logic [L-1:0][plr_pkg::W_SQ-1:0]   r_b_sq;
    logic [L-1:0][plr_pkg::W_POS-1:0]  r_b_origin;
    logic [L-1:0][plr_pkg::W_NRM-1:0]  r_b_nrm;
    logic [L-1:0][plr_pkg::W_AD-1:0]   r_b_ad;
    logic [L-1:0]                      r_b_sd;
    logic [L-1:0][plr_pkg::W_SQ-1:0]   n_b_sq;
    logic [L-1:0][plr_pkg::W_POS-1:0]  n_b_origin;

    always_comb begin
        logic signed [plr_pkg::W_PROD_OFF-1:0] rnd;
        logic signed [plr_pkg::W_PROD_OFF-1:0] sh;
        logic signed [plr_pkg::W_ORG_SUM-1:0]  o;
        for (int k = 0; k < L; k++) begin
            n_b_sq[k] = plr_pkg::W_SQ'(r_a_ad[k]) * plr_pkg::W_SQ'(r_a_ad[k]);
            rnd = $signed(r_a_p[k]) + plr_pkg::OFF_HALF;
            sh  = rnd >>> plr_pkg::DIR_FRAC;
            o   = $signed({{2{r_a_hit[k][plr_pkg::W_POS-1]}}, r_a_hit[k]})
                + $signed({sh[plr_pkg::W_PROD_OFF-1], sh});
            n_b_origin[k] = plr_pkg::sat_s32(o);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (w_en) begin
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_sq     <= n_b_sq;
            r_b_origin <= n_b_origin;
            r_b_nrm    <= r_a_nrm;
            r_b_ad     <= r_a_ad;
            r_b_sd     <= r_a_sd;
        end
    end

    // stage c: squared distance and zero detect
    logic                    r_vc;
    logic [plr_pkg::W_SUM-1:0] r_c_s;
    plr_pkg::t_tag_a         r_c_tag;
    logic [plr_pkg::W_SUM-1:0] n_c_s;
    assign n_c_s = r_b_sq[0] + r_b_sq[1] + r_b_sq[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
        end else if (w_en) begin
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_s          <= n_c_s;
            r_c_tag.origin <= r_b_origin;
            r_c_tag.ad     <= r_b_ad;
            r_c_tag.sd     <= r_b_sd;
            r_c_tag.nrm    <= r_b_nrm;
            r_c_tag.s      <= n_c_s;
            r_c_tag.degen  <= (n_c_s == '0);
        end
    end

    // square root of the squared distance
    logic                       w_sq_valid;
    logic [plr_pkg::W_ROOT-1:0] w_sq_root;
    plr_pkg::t_tag_a            w_sq_tag;

    plr_sqrt #(
        .TW ($bits(plr_pkg::t_tag_a))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_vc),
        .i_s     (r_c_s),
        .i_tag   (r_c_tag),
        .o_valid (w_sq_valid),
        .o_root  (w_sq_root),
        .o_tag   (w_sq_tag)
    );

    // stage d: rounded direction numerators, saturated distance
    logic                                 r_vd;
    logic [L-1:0][plr_pkg::W_DIRN-1:0]    r_d_num;
    logic [plr_pkg::W_ROOT-1:0]           r_d_root;
    plr_pkg::t_tag_b                      r_d_tag;
    logic [L-1:0][plr_pkg::W_DIRN-1:0]    n_d_num;

    always_comb begin
        for (int k = 0; k < L; k++) begin
            n_d_num[k] = {w_sq_tag.ad[k], {plr_pkg::DIR_FRAC{1'b0}}}
                       + plr_pkg::W_DIRN'(w_sq_root >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= 1'b0;
        end else if (w_en) begin
            r_vd <= w_sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_num         <= n_d_num;
            r_d_root        <= w_sq_root;
            r_d_tag.origin  <= w_sq_tag.origin;
            r_d_tag.sd      <= w_sq_tag.sd;
            r_d_tag.nrm     <= w_sq_tag.nrm;
            r_d_tag.ray_len <= (|w_sq_root[plr_pkg::W_ROOT-1:plr_pkg::W_DIST])
                             ? '1 : w_sq_root[plr_pkg::W_DIST-1:0];
            r_d_tag.lo      <= w_sq_tag.s[plr_pkg::W_LO-1:0];
            r_d_tag.hi_nz   <= |w_sq_tag.s[plr_pkg::W_SUM-1:plr_pkg::W_LO];
            r_d_tag.degen   <= w_sq_tag.degen;
        end
    end

    // direction divider
    logic                              w_dd_valid;
    logic [L-1:0][plr_pkg::W_DIRQ-1:0] w_dd_quo;
    plr_pkg::t_tag_b                   w_dd_tag;

    plr_div #(
        .NW (plr_pkg::W_DIRN),
        .DW (plr_pkg::W_ROOT),
        .QW (plr_pkg::W_DIRQ),
        .TW ($bits(plr_pkg::t_tag_b))
    ) u_div_dir (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_vd),
        .i_num   (r_d_num),
        .i_den   (r_d_root),
        .i_tag   (r_d_tag),
        .o_valid (w_dd_valid),
        .o_quo   (w_dd_quo),
        .o_tag   (w_dd_tag)
    );

    // stage e: signed direction and per-axis products with the normal
    logic                               r_ve;
    plr_pkg::t_post                     r_e_post;
    logic [L-1:0][plr_pkg::W_DOT-1:0]   r_e_prod;
    logic [L-1:0][plr_pkg::W_DIR-1:0]   n_e_dir;
    logic [L-1:0][plr_pkg::W_DOT-1:0]   n_e_prod;

    always_comb begin
        logic [plr_pkg::W_DIR-1:0]        q;
        logic signed [plr_pkg::W_DOT-1:0] pr;
        for (int k = 0; k < L; k++) begin
            q = {1'b0, w_dd_quo[k]};
            if (w_dd_tag.degen) begin
                n_e_dir[k] = '0;
            end else if (w_dd_tag.sd[k]) begin
                n_e_dir[k] = ~q + plr_pkg::W_DIR'(1);
            end else begin
                n_e_dir[k] = q;
            end
            pr = $signed(n_e_dir[k]) * $signed(w_dd_tag.nrm[k]);
            n_e_prod[k] = pr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ve <= 1'b0;
        end else if (w_en) begin
            r_ve <= w_dd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_post.origin  <= w_dd_tag.origin;
            r_e_post.dir     <= n_e_dir;
            r_e_post.ray_len <= w_dd_tag.ray_len;
            r_e_post.lo      <= w_dd_tag.lo;
            r_e_post.hi_nz   <= w_dd_tag.hi_nz;
            r_e_post.degen   <= w_dd_tag.degen;
            r_e_post.kill    <= 1'b0;
            r_e_post.ovf     <= '0;
            r_e_prod         <= n_e_prod;
        end
    end

    // stage f: dot product and zero-contribution decision
    logic                       r_vf;
    plr_pkg::t_post             r_f_post;
    plr_pkg::t_post             n_f_post;
    logic [plr_pkg::W_DOT-1:0]  r_f_dot;
    logic [plr_pkg::W_DOT-1:0]  n_f_dot;
    logic [plr_pkg::W_DOT+1:0]  w_f_sum;

    assign w_f_sum = $signed({{2{r_e_prod[0][plr_pkg::W_DOT-1]}}, r_e_prod[0]})
                   + $signed({{2{r_e_prod[1][plr_pkg::W_DOT-1]}}, r_e_prod[1]})
                   + $signed({{2{r_e_prod[2][plr_pkg::W_DOT-1]}}, r_e_prod[2]});
    assign n_f_dot = w_f_sum[plr_pkg::W_DOT-1:0];

    always_comb begin
        n_f_post      = r_e_post;
        n_f_post.kill = r_e_post.degen || r_e_post.hi_nz
                     || n_f_dot[plr_pkg::W_DOT-1] || (n_f_dot == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf <= 1'b0;
        end else if (w_en) begin
            r_vf <= r_ve;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_post <= n_f_post;
            r_f_dot  <= n_f_dot;
        end
    end

    // stage g: color times dot, scaled
    logic                               r_vg;
    plr_pkg::t_post                     r_g_post;
    logic [L-1:0][plr_pkg::W_CNUM-1:0]  r_g_num;
    logic [L-1:0][plr_pkg::W_CNUM-1:0]  n_g_num;

    always_comb begin
        logic [plr_pkg::W_CMUL-1:0] m;
        for (int k = 0; k < L; k++) begin
            m = plr_pkg::W_CMUL'(r_color[k]) * plr_pkg::W_CMUL'(r_f_dot[plr_pkg::W_DOTP-1:0]);
            n_g_num[k] = {m, {plr_pkg::CSHIFT{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vg <= 1'b0;
        end else if (w_en) begin
            r_vg <= r_vf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g_post <= r_f_post;
            r_g_num  <= n_g_num;
        end
    end

    // stage h: quotient overflow check against 2^32
    logic                               r_vh;
    plr_pkg::t_post                     r_h_post;
    plr_pkg::t_post                     n_h_post;
    logic [L-1:0][plr_pkg::W_CNUM-1:0]  r_h_num;
    logic [L-1:0]                       n_h_ovf;

    always_comb begin
        for (int k = 0; k < L; k++) begin
            n_h_ovf[k] = plr_pkg::W_LO'(r_g_num[k][plr_pkg::W_CNUM-1:plr_pkg::W_CQ])
                       >= r_g_post.lo;
        end
        n_h_post     = r_g_post;
        n_h_post.ovf = n_h_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vh <= 1'b0;
        end else if (w_en) begin
            r_vh <= r_vg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_h_post <= n_h_post;
            r_h_num  <= r_g_num;
        end
    end

    // contribution divider
    logic                             w_cd_valid;
    logic [L-1:0][plr_pkg::W_CQ-1:0]  w_cd_quo;
    plr_pkg::t_post                   w_cd_tag;

    plr_div #(
        .NW (plr_pkg::W_CNUM),
        .DW (plr_pkg::W_LO),
        .QW (plr_pkg::W_CQ),
        .TW ($bits(plr_pkg::t_post))
    ) u_div_contrib (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_vh),
        .i_num   (r_h_num),
        .i_den   (r_h_post.lo),
        .i_tag   (r_h_post),
        .o_valid (w_cd_valid),
        .o_quo   (w_cd_quo),
        .o_tag   (w_cd_tag)
    );

    // output register: final contribution selection
    logic [L-1:0][plr_pkg::W_POS-1:0] r_o_origin;
    logic [L-1:0][plr_pkg::W_DIR-1:0] r_o_dir;
    logic [plr_pkg::W_DIST-1:0]       r_o_dist;
    logic [L-1:0][plr_pkg::W_CQ-1:0]  r_o_contrib;
    logic                             r_o_degen;
    logic [L-1:0][plr_pkg::W_CQ-1:0]  n_o_contrib;

    always_comb begin
        for (int k = 0; k < L; k++) begin
            if (w_cd_tag.degen) begin
                n_o_contrib[k] = '1;
            end else if (w_cd_tag.kill) begin
                n_o_contrib[k] = '0;
            end else if (w_cd_tag.ovf[k]) begin
                n_o_contrib[k] = '1;
            end else begin
                n_o_contrib[k] = w_cd_quo[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (w_en) begin
            r_vo <= w_cd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_origin  <= w_cd_tag.origin;
            r_o_dir     <= w_cd_tag.dir;
            r_o_dist    <= w_cd_tag.ray_len;
            r_o_contrib <= n_o_contrib;
            r_o_degen   <= w_cd_tag.degen;
        end
    end

    // result word
    assign o_shade.valid          = r_vo;
    assign o_shade.origin_x       = r_o_origin[0];
    assign o_shade.origin_y       = r_o_origin[1];
    assign o_shade.origin_z       = r_o_origin[2];
    assign o_shade.dir_x          = r_o_dir[0];
    assign o_shade.dir_y          = r_o_dir[1];
    assign o_shade.dir_z          = r_o_dir[2];
    assign o_shade.light_distance = r_o_dist;
    assign o_shade.contrib_red    = r_o_contrib[0];
    assign o_shade.contrib_green  = r_o_contrib[1];
    assign o_shade.contrib_blue   = r_o_contrib[2];
    assign o_shade.degenerate     = r_o_degen;

endmodule

>>> src/plr_sqrt.sv
// pipelined integer square root, one root bit per stage
module plr_sqrt #(
    parameter int TW = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [plr_pkg::W_SUM-1:0]     i_s,
    input  logic [TW-1:0]                 i_tag,
    output logic                          o_valid,
    output logic [plr_pkg::W_ROOT-1:0]    o_root,
    output logic [TW-1:0]                 o_tag
);
    localparam int RW  = plr_pkg::W_ROOT;
    localparam int MW  = plr_pkg::W_REM_SQ;
    localparam int SPW = 2 * RW;

    logic                r_valid [RW];
    logic [RW-1:0]       r_root  [RW];
    logic [MW-1:0]       r_rem   [RW];
    logic [SPW-1:0]      r_s     [RW];
    logic [TW-1:0]       r_tag   [RW];

    for (genvar j = 0; j < RW; j++) begin : g_stage
        localparam int B = 2 * (RW - 1 - j);
        logic          w_valid;
        logic [RW-1:0] w_root;
        logic [MW-1:0] w_rem;
        logic [SPW-1:0] w_s;
        logic [TW-1:0] w_tag;
        logic [RW-1:0] n_root;
        logic [MW-1:0] n_rem;

        // stage input: port for the first stage, previous register otherwise
        if (j == 0) begin : g_first
            assign w_valid = i_valid;
            assign w_root  = '0;
            assign w_rem   = '0;
            assign w_s     = SPW'(i_s);
            assign w_tag   = i_tag;
        end else begin : g_next
            assign w_valid = r_valid[j-1];
            assign w_root  = r_root[j-1];
            assign w_rem   = r_rem[j-1];
            assign w_s     = r_s[j-1];
            assign w_tag   = r_tag[j-1];
        end

        // bring down two bits, try to subtract 4*root+1
        always_comb begin
            logic [MW+1:0] rem_sh;
            logic [MW+1:0] trial;
            rem_sh = {w_rem, w_s[B+1:B]};
            trial  = (MW+2)'({w_root, 2'b01});
            if (rem_sh >= trial) begin
                n_rem  = MW'(rem_sh - trial);
                n_root = {w_root[RW-2:0], 1'b1};
            end else begin
                n_rem  = MW'(rem_sh);
                n_root = {w_root[RW-2:0], 1'b0};
            end
        end

        // stage valid
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j] <= 1'b0;
            end else if (i_en) begin
                r_valid[j] <= w_valid;
            end
        end

        // stage payload
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[j] <= n_root;
                r_rem[j]  <= n_rem;
                r_s[j]    <= w_s;
                r_tag[j]  <= w_tag;
            end
        end
    end

    assign o_valid = r_valid[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_tag   = r_tag[RW-1];

endmodule

>>> src/plr_div.sv
// pipelined restoring divider, three numerators over one shared divisor, one bit per stage
module plr_div #(
    parameter int NW = 47,
    parameter int DW = 34,
    parameter int QW = 15,
    parameter int TW = 1
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  logic [plr_pkg::LANES-1:0][NW-1:0]     i_num,
    input  logic [DW-1:0]                         i_den,
    input  logic [TW-1:0]                         i_tag,
    output logic                                  o_valid,
    output logic [plr_pkg::LANES-1:0][QW-1:0]     o_quo,
    output logic [TW-1:0]                         o_tag
);
    localparam int L = plr_pkg::LANES;

    logic                      r_valid [QW];
    logic [L-1:0][NW-1:0]      r_num   [QW];
    logic [L-1:0][DW-1:0]      r_rem   [QW];
    logic [L-1:0][QW-1:0]      r_quo   [QW];
    logic [DW-1:0]             r_den   [QW];
    logic [TW-1:0]             r_tag   [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int B = QW - 1 - k;
        logic                 w_valid;
        logic [L-1:0][NW-1:0] w_num;
        logic [L-1:0][DW-1:0] w_rem;
        logic [L-1:0][QW-1:0] w_quo;
        logic [DW-1:0]        w_den;
        logic [TW-1:0]        w_tag;
        logic [L-1:0][DW-1:0] n_rem;
        logic [L-1:0][QW-1:0] n_quo;

        // stage input: the first stage starts from the numerator's top bits
        if (k == 0) begin : g_first
            always_comb begin
                w_valid = i_valid;
                w_num   = i_num;
                w_den   = i_den;
                w_tag   = i_tag;
                w_quo   = '0;
                for (int l = 0; l < L; l++) begin
                    w_rem[l] = DW'(i_num[l] >> QW);
                end
            end
        end else begin : g_next
            assign w_valid = r_valid[k-1];
            assign w_num   = r_num[k-1];
            assign w_rem   = r_rem[k-1];
            assign w_quo   = r_quo[k-1];
            assign w_den   = r_den[k-1];
            assign w_tag   = r_tag[k-1];
        end

        // one quotient bit per lane
        always_comb begin
            logic [DW:0] t;
            for (int l = 0; l < L; l++) begin
                t = {w_rem[l], w_num[l][B]};
                if (t >= {1'b0, w_den}) begin
                    n_rem[l] = DW'(t - {1'b0, w_den});
                    n_quo[l] = {w_quo[l][QW-2:0], 1'b1};
                end else begin
                    n_rem[l] = DW'(t);
                    n_quo[l] = {w_quo[l][QW-2:0], 1'b0};
                end
            end
        end

        // stage valid
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= w_valid;
            end
        end

        // stage payload
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k] <= w_num;
                r_rem[k] <= n_rem;
                r_quo[k] <= n_quo;
                r_den[k] <= w_den;
                r_tag[k] <= w_tag;
            end
        end
    end

    assign o_valid = r_valid[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_tag   = r_tag[QW-1];

endmodule
